// ===== rtl/core/mipds_pkg.sv =====
// ----------------------------------------------------------------------------
// mipds_pkg
// Shared types, register codes and the sRGB conversion tables of the 2x2
// mipmap downsampler. The tables are built at elaboration in Q30 fixed point.
// ----------------------------------------------------------------------------
package mipds_pkg;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned SRC_WIDTH_W  = 13;
  localparam int unsigned SRC_HEIGHT_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SRGB_MODE     = 2'd2;

  // pixel packing: red in the low byte, then green, blue, alpha
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PIXEL_W = 32;
  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [CHAN_W-1:0]  chan_t;

  // linear light values and their four-pixel sum
  localparam int unsigned DEC_W   = 16;
  localparam int unsigned DSUM_W  = 18;
  localparam int unsigned ENC_RND = 131072;
  localparam int unsigned ENC_SHIFT = 18;

  typedef struct packed {
    logic srgb;
    logic row_end;
    logic frame_end;
  } tag_t;

  typedef logic [DEC_W-1:0] dec_table_t [256];
  typedef logic [31:0]      thr_table_t [256];

  localparam longint unsigned Q30 = 64'd1073741824;

  function automatic longint unsigned fifth_power_q30(longint unsigned z);
    longint unsigned p;
    p = z;
    for (int n = 0; n < 4; n++) begin
      p = (p * z) >> 30;
    end
    return p;
  endfunction

  // sRGB to linear of k/510, Q30
  function automatic longint unsigned to_linear_q30(longint unsigned k);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (k * 64'd100000 <= 64'd2062950) begin
      return (k * 64'd100 * Q30 + 64'd329460) / 64'd658920;
    end
    u = ((64'd1000 * k + 64'd28050) * Q30 + 64'd269025) / 64'd538050;
    if (u > Q30) begin
      u = Q30;
    end
    u2 = (u * u) >> 30;
    lo = 64'd0;
    hi = Q30;
    // largest z with z^5 <= u^2, so u^2 * z is u^2.4
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (fifth_power_q30(mid) <= u2) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return (u2 * lo + (Q30 >> 1)) >> 30;
  endfunction

  function automatic dec_table_t build_decode_table();
    dec_table_t tbl;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      v = (to_linear_q30(64'(2 * i)) + 64'd8192) >> 14;
      tbl[i] = (v > 64'd65535) ? 16'hffff : v[15:0];
    end
    return tbl;
  endfunction

  // linear value of the midpoint below each code
  function automatic thr_table_t build_thresholds();
    thr_table_t thr;
    longint unsigned v;
    thr[0] = 32'd0;
    for (int b = 1; b < 256; b++) begin
      v = to_linear_q30(64'(2 * b - 1));
      thr[b] = v[31:0];
    end
    return thr;
  endfunction

  localparam dec_table_t DECODE_TABLE = build_decode_table();

endpackage

// ===== rtl/core/mip_downsample_2x2_core.sv =====
// ----------------------------------------------------------------------------
// mip_downsample_2x2_core
// Streaming 2x2 box filter producing the next mip level of an RGBA8 image.
// ----------------------------------------------------------------------------
// Source pixels enter on the s_* channel in row-major order, one per request.
// Each finished 2x2 block leaves as one pixel on the m_* channel on the
// request that carries the block's last source pixel; tlast marks the end
// of an output row and tuser the last pixel of the image.
// Source size and sRGB mode are set through the cfg_* write port while idle.
// Throughput: one source pixel per clock while s_tready is high; a result passes
// through the five pipeline registers after the request that completes its block.
// The even source row is kept in two single-port line-buffer banks (even and
// odd columns, registered reads), so both upper neighbors come out in a single read.
// Pipeline: line-buffer read, sRGB decode, linear sum, encode index, encode
// ROM read into the output register.
// When the receiver stalls, empty pipeline slots are squeezed out first and
// input keeps flowing; s_tready drops only once all five stages hold results.
// Reset clears the counters and the pipeline and sets a 1x1 image in plain
// mode; the line buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module mip_downsample_2x2_core #(
  parameter int MAX_WIDTH    = 4096,
  parameter int ENCODE_STEPS = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // source pixels
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [31:0]                          s_tdata,  // red, green, blue, alpha
  // output pixels
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [31:0]                          m_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                                 m_tlast,  // row_end
  output logic                                 m_tuser,  // frame_end
  // configuration
  input  logic                                 cfg_we,
  input  logic [mipds_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mipds_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int CMPW       = (WW > 13) ? WW : 13;
  localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int EW         = $clog2(ENCODE_STEPS + 1);
  localparam int PW         = mipds_pkg::DSUM_W + 1 + EW;

  typedef logic [7:0] enc_rom_t [ENCODE_STEPS+1];

  // code b counts the midpoints at or below the linear value i/ENCODE_STEPS
  function automatic enc_rom_t build_encode_rom();
    enc_rom_t rom;
    mipds_pkg::thr_table_t thr;
    int unsigned b;
    longint unsigned lhs;
    thr = mipds_pkg::build_thresholds();
    b = 1;
    for (int i = 0; i <= ENCODE_STEPS; i++) begin
      lhs = 64'(i) * mipds_pkg::Q30;
      while (b < 256 && lhs >= 64'(ENCODE_STEPS) * 64'(thr[b])) begin
        b = b + 1;
      end
      rom[i] = 8'(b - 1);
    end
    return rom;
  endfunction

  localparam enc_rom_t ENC_ROM = build_encode_rom();

  // configuration registers
  logic [mipds_pkg::SRC_WIDTH_W-1:0]  source_width;
  logic [mipds_pkg::SRC_HEIGHT_W-1:0] source_height;
  logic                               srgb_mode;

  // position of the next source pixel
  logic [CW-1:0]                      column_count;
  logic [15:0]                        row_count;
  mipds_pkg::pixel_t                  left_pixel;

  // even source row, split by column parity
  mipds_pkg::pixel_t bank_even [BANK_DEPTH];
  mipds_pkg::pixel_t bank_odd  [BANK_DEPTH];

  logic [CMPW-1:0] w_ext;
  logic [WW-1:0]   w_eff;
  logic [WW-1:0]   w_even;
  logic [WW-1:0]   x_ext;
  logic [WW-1:0]   x_inc;
  logic [15:0]     h_eff;
  logic [15:0]     h_even;
  logic [16:0]     y_inc;
  logic            w1;
  logic            h1;
  logic            col_hit;
  logic            row_hit;
  logic            emit;
  logic            last_col;
  logic            last_row;
  logic            s_accept;
  logic [BAW-1:0]  bank_addr;
  mipds_pkg::pixel_t cur;

  logic en1, en2, en3, en4, en5;

  // stage 1: block pixels and line-buffer data
  logic              v1;
  mipds_pkg::tag_t   s1_tag;
  logic              s1_w1;
  logic              s1_h1;
  mipds_pkg::pixel_t s1_cur;
  mipds_pkg::pixel_t s1_left;
  mipds_pkg::pixel_t rd_even;
  mipds_pkg::pixel_t rd_odd;

  // stage 2: decoded color and plain averages
  logic              v2;
  mipds_pkg::tag_t   s2_tag;
  logic [mipds_pkg::DEC_W-1:0] s2_dec [4][3];
  mipds_pkg::chan_t  s2_plain [4];

  // stage 3: linear sums
  logic              v3;
  mipds_pkg::tag_t   s3_tag;
  logic [mipds_pkg::DSUM_W-1:0] s3_dsum [3];
  mipds_pkg::chan_t  s3_plain [4];

  // stage 4: encode index
  logic              v4;
  mipds_pkg::tag_t   s4_tag;
  logic [EW-1:0]     s4_idx [3];
  mipds_pkg::chan_t  s4_plain [4];

  // stage 5: output register
  logic              v5;
  mipds_pkg::tag_t   s5_tag;
  mipds_pkg::chan_t  enc_q [3];
  mipds_pkg::chan_t  s5_plain [4];

  mipds_pkg::pixel_t blk [4];
  mipds_pkg::chan_t  plain_avg [4];
  logic [mipds_pkg::DSUM_W-1:0] dsum [3];
  logic [PW-1:0]     prod [3];
  logic [EW:0]       idx_raw [3];
  logic [EW-1:0]     idx [3];

  assign cur      = mipds_pkg::pixel_t'(s_tdata);
  assign s_accept = s_tvalid & s_tready;

  // a result moves on when the slot ahead is empty or moving
  assign en5      = ~v5 | m_tready;
  assign en4      = ~v4 | en5;
  assign en3      = ~v3 | en4;
  assign en2      = ~v2 | en3;
  assign en1      = ~v1 | en2;
  assign s_tready = en1;

  // block position
  always_comb begin
    w_ext = CMPW'(source_width);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_ext);
    end
    w_even   = {w_eff[WW-1:1], 1'b0};
    x_ext    = WW'(column_count);
    x_inc    = x_ext + WW'(1);
    h_eff    = (source_height == 16'd0) ? 16'd1 : source_height;
    h_even   = {h_eff[15:1], 1'b0};
    y_inc    = {1'b0, row_count} + 17'd1;
    w1       = (w_eff == WW'(1));
    h1       = (h_eff == 16'd1);
    col_hit  = w1 ? (column_count == '0) : (column_count[0] && (x_ext < w_eff));
    row_hit  = h1 ? (row_count == 16'd0) : (row_count[0] && (row_count < h_eff));
    emit     = col_hit & row_hit;
    last_col = w1 | (x_ext == w_even - WW'(1));
    last_row = h1 | (row_count == h_even - 16'd1);
    bank_addr = BAW'(column_count >> 1);
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 13'd1;
      source_height <= 16'd1;
      srgb_mode     <= 1'b0;
      column_count  <= '0;
      row_count     <= 16'd0;
      left_pixel    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mipds_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[12:0];
          mipds_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[15:0];
          mipds_pkg::REG_SRGB_MODE:     srgb_mode     <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_accept) begin
        left_pixel <= cur;
        if (x_inc >= w_eff) begin
          column_count <= '0;
          row_count    <= (y_inc >= {1'b0, h_eff}) ? 16'd0 : y_inc[15:0];
        end else begin
          column_count <= CW'(x_inc);
        end
      end
    end
  end

  // line buffer: even rows write, every request reads both banks
  always_ff @(posedge clk) begin
    if (s_accept) begin
      if (!row_count[0]) begin
        if (column_count[0]) begin
          bank_odd[bank_addr] <= cur;
        end else begin
          bank_even[bank_addr] <= cur;
        end
      end
      rd_even <= bank_even[bank_addr];
      rd_odd  <= bank_odd[bank_addr];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_tag.srgb      <= srgb_mode;
      s1_tag.row_end   <= last_col;
      s1_tag.frame_end <= last_col & last_row;
      s1_w1            <= w1;
      s1_h1            <= h1;
      s1_cur           <= cur;
      s1_left          <= left_pixel;
    end
  end

  // assemble the block: upper left, upper right, lower left, lower right
  always_comb begin
    logic [9:0] sum;
    blk[3] = s1_cur;
    blk[2] = s1_w1 ? s1_cur : s1_left;
    blk[1] = s1_h1 ? blk[3] : (s1_w1 ? rd_even : rd_odd);
    blk[0] = s1_h1 ? blk[2] : rd_even;
    for (int c = 0; c < 4; c++) begin
      sum = 10'(blk[0][8*c +: 8]) + 10'(blk[1][8*c +: 8]) +
            10'(blk[2][8*c +: 8]) + 10'(blk[3][8*c +: 8]) + 10'd2;
      plain_avg[c] = sum[9:2];
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_tag <= s1_tag;
      for (int j = 0; j < 4; j++) begin
        for (int c = 0; c < 3; c++) begin
          s2_dec[j][c] <= mipds_pkg::DECODE_TABLE[blk[j][8*c +: 8]];
        end
      end
      s2_plain <= plain_avg;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dsum[c] = mipds_pkg::DSUM_W'(s2_dec[0][c]) + mipds_pkg::DSUM_W'(s2_dec[1][c]) +
                mipds_pkg::DSUM_W'(s2_dec[2][c]) + mipds_pkg::DSUM_W'(s2_dec[3][c]);
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_tag   <= s2_tag;
      s3_dsum  <= dsum;
      s3_plain <= s2_plain;
    end
  end

  // rounded table index, saturated at the top entry
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]    = PW'(s3_dsum[c]) * PW'(ENCODE_STEPS) + PW'(mipds_pkg::ENC_RND);
      idx_raw[c] = prod[c][PW-1:mipds_pkg::ENC_SHIFT];
      idx[c]     = (idx_raw[c] > (EW+1)'(ENCODE_STEPS)) ? EW'(ENCODE_STEPS)
                                                         : idx_raw[c][EW-1:0];
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_tag   <= s3_tag;
      s4_idx   <= idx;
      s4_plain <= s3_plain;
    end
  end

  // stage 5: one encode ROM per color channel
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_tag   <= s4_tag;
      s5_plain <= s4_plain;
      for (int c = 0; c < 3; c++) begin
        enc_q[c] <= ENC_ROM[s4_idx[c]];
      end
    end
  end

  assign m_tvalid       = v5;
  assign m_tdata[7:0]   = s5_tag.srgb ? enc_q[0] : s5_plain[0];
  assign m_tdata[15:8]  = s5_tag.srgb ? enc_q[1] : s5_plain[1];
  assign m_tdata[23:16] = s5_tag.srgb ? enc_q[2] : s5_plain[2];
  assign m_tdata[31:24] = s5_plain[3];
  assign m_tlast        = s5_tag.row_end;
  assign m_tuser        = s5_tag.frame_end;

endmodule
